@@ design/sdtf_pkg.sv @@
`timescale 1ns / 1ps

package sdtf_pkg;

   localparam int BYTE_W  = 8;
   localparam int DEPTH_W = 8;
   localparam int TALLY_W = 16;
   localparam int CSR_W   = 2;

   localparam int WORD_MAX_DEF  = 32;
   localparam int DEPTH_MAX_DEF = 255;

   localparam logic [CSR_W-1:0] CSR_KEEP_MARKUP = 2'd0;
   localparam logic [CSR_W-1:0] CSR_KEEP_PAREN  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_KEEP_NAMES  = 2'd2;

   localparam logic [BYTE_W-1:0] CH_LT      = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_GT      = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
   localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;
   localparam logic [BYTE_W-1:0] CH_COLON   = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_TILDE   = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;

endpackage

@@ design/sdtf_word_buf.sv @@
`timescale 1ns / 1ps

module sdtf_word_buf import sdtf_pkg::*; #(
   parameter int WORD_MAX = WORD_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(WORD_MAX)-1:0] wr_addr,
   input  logic [BYTE_W-1:0]           wr_data,
   input  logic [$clog2(WORD_MAX)-1:0] rd_addr,
   output logic [BYTE_W-1:0]           rd_data
);

   logic [BYTE_W-1:0] mem [WORD_MAX];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-through so a read of the address being written sees the new byte
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/subtitle_dialogue_text_filter.sv @@
// a request is accepted in idle, then a planning state, then the results (up to
// WORD_MAX + 1), with a store state when a word character is buffered; a new
// request is taken only back in idle; the sequencer drains the word buffer one
// byte a cycle, unless the receiver stalls, through its single read port
// reset: synchronous active-high reset clears the sequencer, cue state, settings
// and rsp_valid; the data registers and the word buffer contents are not cleared
`timescale 1ns / 1ps

module subtitle_dialogue_text_filter import sdtf_pkg::*; #(
   parameter int WORD_MAX  = WORD_MAX_DEF,
   parameter int DEPTH_MAX = DEPTH_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_char_byte,
   input  logic               req_char_present,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_out_valid,
   output logic               rsp_run_last,
   output logic               rsp_cue_done,
   output logic [TALLY_W-1:0] rsp_speakers_found,
   output logic               rsp_dialogue_empty,
   output logic               rsp_overflow_seen,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_index,
   input  logic               csr_data
);

   localparam int ADDR_W = $clog2(WORD_MAX);
   localparam int LEN_W  = $clog2(WORD_MAX + 1);

   localparam logic [LEN_W-1:0]   LEN_MAX = LEN_W'(WORD_MAX);
   localparam logic [DEPTH_W-1:0] DMAX    = DEPTH_W'(DEPTH_MAX);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PLAN  = 3'd1;
   localparam logic [2:0] S_FL1   = 3'd2;
   localparam logic [2:0] S_CHAR  = 3'd3;
   localparam logic [2:0] S_STORE = 3'd4;
   localparam logic [2:0] S_FL2   = 3'd5;
   localparam logic [2:0] S_NULL  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic               keep_markup_ff, keep_markup_in;
   logic               keep_paren_ff, keep_paren_in;
   logic               keep_names_ff, keep_names_in;
   logic [DEPTH_W-1:0] tag_depth_ff, tag_depth_in;
   logic [DEPTH_W-1:0] paren_depth_ff, paren_depth_in;
   logic [LEN_W-1:0]   word_length_ff, word_length_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic               after_colon_ff, after_colon_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic               emitted_ff, emitted_in;
   logic               ovf_ff, ovf_in;
   logic [BYTE_W-1:0]  char_ff, char_in;
   logic               pre_ff, pre_in;
   logic               emit_ff, emit_in;
   logic               store_ff, store_in;
   logic               end_ff, end_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_bvalid_ff, rsp_bvalid_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_done_ff, rsp_done_in;
   logic [TALLY_W-1:0] rsp_spk_ff, rsp_spk_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               accept;
   logic               out_free;
   logic               vis_tag, vis_paren, staged;
   logic               ovf_tag, ovf_paren;
   logic [DEPTH_W-1:0] tag_nx, paren_nx;
   logic               last_idx;
   logic               produce;
   logic [BYTE_W-1:0]  p_byte;
   logic               p_valid;
   logic               p_last;
   logic               p_done;
   logic               wr_en;
   logic [BYTE_W-1:0]  rd_data;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign last_idx  = ((cnt_ff + LEN_W'(1)) == word_length_ff);
   assign wr_en     = (state_ff == S_STORE);

   // nesting stages for tags, then parentheses
   always_comb begin
      vis_tag = 1'b1;
      tag_nx  = tag_depth_ff;
      ovf_tag = 1'b0;
      if (!keep_markup_ff) begin
         if (req_char_byte == CH_LT) begin
            vis_tag = 1'b0;
            if (tag_depth_ff < DMAX) begin
               tag_nx = tag_depth_ff + DEPTH_W'(1);
            end else begin
               ovf_tag = 1'b1;
            end
         end else if (tag_depth_ff != '0) begin
            vis_tag = 1'b0;
            if (req_char_byte == CH_GT) begin
               tag_nx = tag_depth_ff - DEPTH_W'(1);
            end
         end
      end
      vis_paren = vis_tag;
      paren_nx  = paren_depth_ff;
      ovf_paren = 1'b0;
      if (vis_tag && !keep_paren_ff) begin
         if (req_char_byte == CH_LPAREN) begin
            vis_paren = 1'b0;
            if (paren_depth_ff < DMAX) begin
               paren_nx = paren_depth_ff + DEPTH_W'(1);
            end else begin
               ovf_paren = 1'b1;
            end
         end else if (paren_depth_ff != '0) begin
            vis_paren = 1'b0;
            if (req_char_byte == CH_RPAREN) begin
               paren_nx = paren_depth_ff - DEPTH_W'(1);
            end
         end
      end
      staged = req_char_present && vis_paren && (req_char_byte != CH_TILDE);
   end

   always_comb begin
      state_in       = state_ff;
      keep_markup_in = keep_markup_ff;
      keep_paren_in  = keep_paren_ff;
      keep_names_in  = keep_names_ff;
      tag_depth_in   = tag_depth_ff;
      paren_depth_in = paren_depth_ff;
      word_length_in = word_length_ff;
      cnt_in         = cnt_ff;
      after_colon_in = after_colon_ff;
      tally_in       = tally_ff;
      emitted_in     = emitted_ff;
      ovf_in         = ovf_ff;
      char_in        = char_ff;
      pre_in         = pre_ff;
      emit_in        = emit_ff;
      store_in       = store_ff;
      end_in         = end_ff;
      produce        = 1'b0;
      p_byte         = '0;
      p_valid        = 1'b0;
      p_last         = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEEP_MARKUP: keep_markup_in = csr_data;
            CSR_KEEP_PAREN:  keep_paren_in  = csr_data;
            CSR_KEEP_NAMES:  keep_names_in  = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PLAN;
               char_in  = req_char_byte;
               end_in   = req_end_of_text;
               pre_in   = 1'b0;
               emit_in  = 1'b0;
               store_in = 1'b0;
               cnt_in   = '0;
               if (req_char_present) begin
                  tag_depth_in   = tag_nx;
                  paren_depth_in = paren_nx;
                  if (ovf_tag || ovf_paren) begin
                     ovf_in = 1'b1;
                  end
               end
               if (staged) begin
                  if (keep_names_ff) begin
                     pre_in         = 1'b1;
                     emit_in        = 1'b1;
                     after_colon_in = 1'b0;
                  end else if (after_colon_ff && (req_char_byte == CH_SPACE)) begin
                     after_colon_in = 1'b0;
                  end else begin
                     after_colon_in = 1'b0;
                     if (req_char_byte == CH_COLON) begin
                        word_length_in = '0;
                        after_colon_in = 1'b1;
                        if (tally_ff != '1) begin
                           tally_in = tally_ff + TALLY_W'(1);
                        end
                     end else if ((req_char_byte == CH_SPACE) ||
                                  (req_char_byte == CH_NEWLINE)) begin
                        pre_in  = 1'b1;
                        emit_in = 1'b1;
                     end else begin
                        store_in = 1'b1;
                        if (word_length_ff >= LEN_MAX) begin
                           pre_in = 1'b1;
                           ovf_in = 1'b1;
                        end
                     end
                  end
               end
            end
         end
         S_PLAN: begin
            priority if (pre_ff && (word_length_ff != '0)) begin
               state_in = S_FL1;
            end else if (emit_ff) begin
               state_in = S_CHAR;
            end else if (store_ff) begin
               state_in = S_STORE;
            end else if (end_ff && (word_length_ff != '0)) begin
               state_in = S_FL2;
            end else if (end_ff) begin
               state_in = S_NULL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FL1: begin
            if (out_free) begin
               produce = 1'b1;
               p_byte  = rd_data;
               p_valid = 1'b1;
               p_last  = last_idx && !emit_ff && !(store_ff && end_ff);
               cnt_in  = cnt_ff + LEN_W'(1);
               if (last_idx) begin
                  cnt_in         = '0;
                  word_length_in = '0;
                  priority if (emit_ff) begin
                     state_in = S_CHAR;
                  end else if (store_ff) begin
                     state_in = S_STORE;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_CHAR: begin
            if (out_free) begin
               produce  = 1'b1;
               p_byte   = char_ff;
               p_valid  = 1'b1;
               p_last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_STORE: begin
            word_length_in = word_length_ff + LEN_W'(1);
            cnt_in         = '0;
            state_in       = end_ff ? S_FL2 : S_IDLE;
         end
         S_FL2: begin
            if (out_free) begin
               produce = 1'b1;
               p_byte  = rd_data;
               p_valid = 1'b1;
               p_last  = last_idx;
               cnt_in  = cnt_ff + LEN_W'(1);
               if (last_idx) begin
                  cnt_in         = '0;
                  word_length_in = '0;
                  state_in       = S_IDLE;
               end
            end
         end
         S_NULL: begin
            if (out_free) begin
               produce  = 1'b1;
               p_last   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      p_done = p_last && end_ff;

      if (produce) begin
         emitted_in = emitted_ff || p_valid;
      end

      // end of cue returns all cue state to reset values
      if (produce && p_done) begin
         tag_depth_in   = '0;
         paren_depth_in = '0;
         word_length_in = '0;
         after_colon_in = 1'b0;
         tally_in       = '0;
         emitted_in     = 1'b0;
         ovf_in         = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_spk_in    = rsp_spk_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (produce) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = p_byte;
         rsp_bvalid_in = p_valid;
         rsp_last_in   = p_last;
         rsp_done_in   = p_done;
         rsp_spk_in    = p_done ? tally_ff : '0;
         rsp_empty_in  = p_done && !(emitted_ff || p_valid);
         rsp_ovf_in    = p_done && ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         keep_markup_ff <= 1'b0;
         keep_paren_ff  <= 1'b0;
         keep_names_ff  <= 1'b0;
         tag_depth_ff   <= '0;
         paren_depth_ff <= '0;
         word_length_ff <= '0;
         cnt_ff         <= '0;
         after_colon_ff <= 1'b0;
         tally_ff       <= '0;
         emitted_ff     <= 1'b0;
         ovf_ff         <= 1'b0;
         pre_ff         <= 1'b0;
         emit_ff        <= 1'b0;
         store_ff       <= 1'b0;
         end_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         keep_markup_ff <= keep_markup_in;
         keep_paren_ff  <= keep_paren_in;
         keep_names_ff  <= keep_names_in;
         tag_depth_ff   <= tag_depth_in;
         paren_depth_ff <= paren_depth_in;
         word_length_ff <= word_length_in;
         cnt_ff         <= cnt_in;
         after_colon_ff <= after_colon_in;
         tally_ff       <= tally_in;
         emitted_ff     <= emitted_in;
         ovf_ff         <= ovf_in;
         pre_ff         <= pre_in;
         emit_ff        <= emit_in;
         store_ff       <= store_in;
         end_ff         <= end_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_spk_ff    <= rsp_spk_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   sdtf_word_buf #(
      .WORD_MAX (WORD_MAX)
   ) u_word_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_length_ff[ADDR_W-1:0]),
      .wr_data (char_ff),
      .rd_addr (cnt_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_out_valid      = rsp_bvalid_ff;
   assign rsp_run_last       = rsp_last_ff;
   assign rsp_cue_done       = rsp_done_ff;
   assign rsp_speakers_found = rsp_spk_ff;
   assign rsp_dialogue_empty = rsp_empty_ff;
   assign rsp_overflow_seen  = rsp_ovf_ff;

endmodule

@@ design/sdtf_checker.sv @@
`timescale 1ns / 1ps

module sdtf_checker import sdtf_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [BYTE_W-1:0]  rsp_out_byte,
   input logic               rsp_out_valid,
   input logic               rsp_run_last,
   input logic               rsp_cue_done,
   input logic [TALLY_W-1:0] rsp_speakers_found,
   input logic               rsp_dialogue_empty,
   input logic               rsp_overflow_seen
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
         $stable(rsp_out_valid) && $stable(rsp_run_last) && $stable(rsp_cue_done))
      else $error("stalled response changed");

   // end of cue is always the last result of its request
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cue_done |-> rsp_run_last)
      else $error("cue_done without run_last");

   // summary fields only at end of cue
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cue_done |->
         (rsp_speakers_found == '0) && !rsp_dialogue_empty && !rsp_overflow_seen)
      else $error("summary field set before end of cue");

   // a result without a character only closes a cue
   a_null_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_cue_done && (rsp_out_byte == '0))
      else $error("empty result not at end of cue");

   // empty dialogue cannot carry a character
   a_empty_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dialogue_empty |-> !rsp_out_valid)
      else $error("dialogue_empty with a character");

endmodule

bind subtitle_dialogue_text_filter sdtf_checker u_sdtf_checker (.*);

@@ test/subtitle_dialogue_text_filter_tb.sv @@
`timescale 1ns / 1ps

module subtitle_dialogue_text_filter_tb;
   import sdtf_pkg::*;

   localparam logic [CSR_W-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_ITEMS   = 80;
   localparam int LONG_WORD      = 40;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 200;
   localparam int QUIET_LIMIT    = 1000;

   typedef struct packed {
      logic [BYTE_W-1:0]  text_byte;
      logic               text_valid;
      logic               run_last;
      logic               cue_done;
      logic [TALLY_W-1:0] speakers;
      logic               empty;
      logic               overflow;
   } cue_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_char_byte = '0;
   logic               req_char_present = 1'b0;
   logic               req_end_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [BYTE_W-1:0]  rsp_out_byte;
   logic               rsp_out_valid;
   logic               rsp_run_last;
   logic               rsp_cue_done;
   logic [TALLY_W-1:0] rsp_speakers_found;
   logic               rsp_dialogue_empty;
   logic               rsp_overflow_seen;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_index = '0;
   logic               csr_data = 1'b0;

   // filter model state
   bit                 keep_markup_cfg;
   bit                 keep_paren_cfg;
   bit                 keep_names_cfg;
   logic [DEPTH_W-1:0] tag_level;
   logic [DEPTH_W-1:0] paren_level;
   logic [BYTE_W-1:0]  word_buf [0:WORD_MAX_DEF-1];
   int                 word_len;
   bit                 colon_pending;
   logic [TALLY_W-1:0] speaker_count;
   bit                 any_emitted;
   bit                 overflowed;

   cue_result_type     step_results[$];
   cue_result_type     cleaned_q[$];

   int                 failures;
   int                 requests_sent;
   int                 quiet_cycles;
   bit                 calm;
   bit                 hold_request;

   subtitle_dialogue_text_filter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_byte      (req_char_byte),
      .req_char_present   (req_char_present),
      .req_end_of_text    (req_end_of_text),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_run_last       (rsp_run_last),
      .rsp_cue_done       (rsp_cue_done),
      .rsp_speakers_found (rsp_speakers_found),
      .rsp_dialogue_empty (rsp_dialogue_empty),
      .rsp_overflow_seen  (rsp_overflow_seen),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic void clear_cue_state();
      tag_level     = '0;
      paren_level   = '0;
      word_len      = 0;
      colon_pending = 1'b0;
      speaker_count = '0;
      any_emitted   = 1'b0;
      overflowed    = 1'b0;
   endfunction

   function automatic void emit(input logic [BYTE_W-1:0] ch, input bit shown);
      cue_result_type r;
      r = '0;
      r.text_byte  = ch;
      r.text_valid = shown;
      step_results.insert(step_results.size(), r);
      if (shown) any_emitted = 1'b1;
   endfunction

   function automatic void flush_word();
      for (int i = 0; i < word_len; i++) emit(word_buf[i], 1'b1);
      word_len = 0;
   endfunction

   // one nesting stage, returns 1 while the character stays visible
   function automatic bit nest_pass(input logic [BYTE_W-1:0] ch, input bit parens);
      logic [DEPTH_W-1:0] level;
      logic [BYTE_W-1:0]  opener;
      logic [BYTE_W-1:0]  closer;
      bit                 shown;
      level  = parens ? paren_level : tag_level;
      opener = parens ? CH_LPAREN : CH_LT;
      closer = parens ? CH_RPAREN : CH_GT;
      shown  = 1'b0;
      if (ch == opener) begin
         if (level < DEPTH_MAX_DEF) level++;
         else overflowed = 1'b1;
      end else if (level != 0) begin
         if (ch == closer) level--;
      end else begin
         shown = 1'b1;
      end
      if (parens) paren_level = level;
      else tag_level = level;
      return shown;
   endfunction

   function automatic void filter_step(input logic [BYTE_W-1:0] ch, input bit present,
                                       input bit last);
      bit             shown;
      cue_result_type r;
      step_results.delete();
      if (present) begin
         shown = 1'b1;
         if (!keep_markup_cfg) shown = nest_pass(ch, 1'b0);
         if (shown && !keep_paren_cfg) shown = nest_pass(ch, 1'b1);
         if (shown && ch != CH_TILDE) begin
            if (keep_names_cfg) begin
               flush_word();
               colon_pending = 1'b0;
               emit(ch, 1'b1);
            end else if (colon_pending && ch == CH_SPACE) begin
               colon_pending = 1'b0;
            end else begin
               colon_pending = 1'b0;
               if (ch == CH_COLON) begin
                  word_len      = 0;
                  colon_pending = 1'b1;
                  if (speaker_count != '1) speaker_count++;
               end else if (ch == CH_SPACE || ch == CH_NEWLINE) begin
                  flush_word();
                  emit(ch, 1'b1);
               end else begin
                  if (word_len >= WORD_MAX_DEF) begin
                     flush_word();
                     overflowed = 1'b1;
                  end
                  word_buf[word_len] = ch;
                  word_len++;
               end
            end
         end
      end
      if (last) begin
         flush_word();
         if (step_results.size() == 0) emit('0, 1'b0);
      end
      for (int i = 0; i < step_results.size(); i++) begin
         r = step_results[i];
         if (i == step_results.size() - 1) begin
            r.run_last = 1'b1;
            if (last) begin
               r.cue_done = 1'b1;
               r.speakers = speaker_count;
               r.empty    = !any_emitted;
               r.overflow = overflowed;
            end
         end
         cleaned_q.insert(cleaned_q.size(), r);
      end
      if (last) clear_cue_state();
   endfunction

   function automatic void apply_register(input logic [CSR_W-1:0] idx, input logic value);
      case (idx)
         CSR_KEEP_MARKUP: keep_markup_cfg = value;
         CSR_KEEP_PAREN:  keep_paren_cfg  = value;
         CSR_KEEP_NAMES:  keep_names_cfg  = value;
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [TALLY_W-1:0] want,
                                         input logic [TALLY_W-1:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_result();
      cue_result_type want;
      if (cleaned_q.size() == 0) begin
         $error("response with nothing expected, out_byte %0h", rsp_out_byte);
         failures++;
         return;
      end
      want = cleaned_q.pop_front();
      compare_field("out_byte", TALLY_W'(want.text_byte), TALLY_W'(rsp_out_byte));
      compare_field("out_valid", TALLY_W'(want.text_valid), TALLY_W'(rsp_out_valid));
      compare_field("run_last", TALLY_W'(want.run_last), TALLY_W'(rsp_run_last));
      compare_field("cue_done", TALLY_W'(want.cue_done), TALLY_W'(rsp_cue_done));
      compare_field("speakers_found", want.speakers, rsp_speakers_found);
      compare_field("dialogue_empty", TALLY_W'(want.empty), TALLY_W'(rsp_dialogue_empty));
      compare_field("overflow_seen", TALLY_W'(want.overflow), TALLY_W'(rsp_overflow_seen));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         keep_markup_cfg = 1'b0;
         keep_paren_cfg  = 1'b0;
         keep_names_cfg  = 1'b0;
         clear_cue_state();
      end else begin
         if (req_valid && !req_stall)
            filter_step(req_char_byte, req_char_present, req_end_of_text);
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (rsp_valid && !rsp_stall) check_result();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL subtitle_dialogue_text_filter");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 14);
         end
      end
   end

   task automatic send_item(input logic [BYTE_W-1:0] ch, input bit present, input bit last);
      while (!calm && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_byte    <= ch;
      req_char_present <= present;
      req_end_of_text  <= last;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   task automatic send_text(input string s, input bit last);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, last && i == s.len() - 1);
   endtask

   // wait until the block has drained and gone idle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cleaned_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_filters(input bit markup, input bit paren, input bit names);
      settle();
      write_reg(CSR_KEEP_MARKUP, markup);
      write_reg(CSR_KEEP_PAREN, paren);
      write_reg(CSR_KEEP_NAMES, names);
      write_reg(CSR_SPARE, 1'($urandom_range(1)));
   endtask

   function automatic logic [BYTE_W-1:0] pick_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return BYTE_W'($urandom_range(8'h61, 8'h7A));
      if (roll < 55) return CH_SPACE;
      if (roll < 60) return CH_NEWLINE;
      if (roll < 66) return CH_COLON;
      if (roll < 70) return CH_TILDE;
      if (roll < 75) return CH_LT;
      if (roll < 80) return CH_GT;
      if (roll < 85) return CH_LPAREN;
      if (roll < 90) return CH_RPAREN;
      return BYTE_W'($urandom_range(255));
   endfunction

   task automatic send_random_cue();
      int n;
      int i;
      bit bare_end;
      n        = $urandom_range(1, 14);
      bare_end = 1'($urandom_range(1));
      if ($urandom_range(99) < 60) begin
         repeat ($urandom_range(1, 6))
            send_item(BYTE_W'($urandom_range(8'h41, 8'h5A)), 1'b1, 1'b0);
         send_item(CH_COLON, 1'b1, 1'b0);
         if ($urandom_range(3) != 0) send_item(CH_SPACE, 1'b1, 1'b0);
      end
      for (i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0) send_item(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
         send_item(pick_char(), 1'b1, !bare_end && i == n - 1);
      end
      if (bare_end) send_item(BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // label at start, double colon, markup, parens, tilde, byte extremes, bare steps
   task automatic test_directed();
      send_text("Al:: <b>(o)</b>~z", 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(CH_NEWLINE, 1'b1, 1'b1);
      send_text("B:\n", 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h00, 1'b0, 1'b1);
   endtask

   task automatic test_names_mid_word();
      set_filters(1'b0, 1'b0, 1'b0);
      send_text("Hey wor", 1'b0);
      set_filters(1'b0, 1'b0, 1'b1);
      send_text("ds: ok", 1'b1);
   endtask

   task automatic test_long_word();
      set_filters(1'b0, 1'b0, 1'b0);
      repeat (LONG_WORD) send_item(BYTE_W'($urandom_range(8'h61, 8'h7A)), 1'b1, 1'b0);
      send_item(CH_SPACE, 1'b1, 1'b1);
   endtask

   task automatic test_backpressure();
      set_filters(1'b1, 1'b0, 1'b1);
      hold_request = 1'b1;
      send_text("so the words go on: and <on> and on", 1'b1);
      set_filters(1'b0, 1'b1, 1'b0);
      hold_request = 1'b1;
      send_text("Jo: so the words go on and on and on ", 1'b1);
   endtask

   task automatic test_random_cues();
      int start;
      int cue_no;
      start  = requests_sent;
      cue_no = 0;
      set_filters(1'b1, 1'b1, 1'b1);
      calm = 1'b1;
      while (requests_sent - start < RANDOM_ITEMS) begin
         if (cue_no == 6) calm = 1'b0;
         if (cue_no == 3) set_filters(1'b0, 1'b0, 1'b0);
         else if (cue_no > 3 && $urandom_range(3) == 0)
            set_filters(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
         send_random_cue();
         cue_no++;
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_names_mid_word();
      test_long_word();
      test_backpressure();
      test_random_cues();
      settle();
      if (failures == 0) begin
         $display("PASS subtitle_dialogue_text_filter");
      end else begin
         $display("FAIL subtitle_dialogue_text_filter");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/sdtf_pkg.sv
design/sdtf_word_buf.sv
design/subtitle_dialogue_text_filter.sv
design/sdtf_checker.sv
test/subtitle_dialogue_text_filter_tb.sv
